### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

### src/pbsc_pkg.sv
// ----------------------------------------------------------------------------
// pbsc_pkg
// widths, register indexes and pipeline sizes of the plane/box section block
// ----------------------------------------------------------------------------
package pbsc_pkg;

  localparam int NORM_W    = 18;
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_EDGES = 12;

  // edge numerator and its magnitude
  localparam int NUM_W = 52;
  localparam int MAG_W = 51;

  // edge divider: quotient bits before saturation, remainder, stages
  localparam int QB          = 33;
  localparam int REM_W       = 18;
  localparam int EDIV_STEPS  = 4;
  localparam int EDIV_STAGES = (QB + EDIV_STEPS - 1) / EDIV_STEPS;
  localparam int EDIV_LAT    = EDIV_STAGES + 2;

  // mean divider
  localparam int SUM_W       = 36;
  localparam int MMAG_W      = 35;
  localparam int MREM_W      = 4;
  localparam int MDIV_STEPS  = 7;
  localparam int MDIV_STAGES = (MMAG_W + MDIV_STEPS - 1) / MDIV_STEPS;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16777216);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2
  } cfg_reg_t;

endpackage

### src/plane_box_section_centroid.sv
// ----------------------------------------------------------------------------
// plane_box_section_centroid
// mean of the plane's hits on the 12 box edges, with count and fallback
// ----------------------------------------------------------------------------
// channel  direction  transfer when      payload
// in       in         start && !busy     in_normal_x/y/z, in_point_x/y/z
// out      out        out_valid          out_centroid_x/y/z, out_point_count,
//                                        out_used_fallback
// cfg      in         cfg_we             cfg_index, cfg_wdata
//
// one item per cycle
// the pipeline holds the 9 stage edge divider and the 5 stage mean divider
// busy is always low; nothing stalls and out_valid lasts one cycle
// synchronous active low reset clears valid bits and presets the box size registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plane_box_section_centroid (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [pbsc_pkg::NORM_W-1:0]     in_normal_x,
  input  logic signed [pbsc_pkg::NORM_W-1:0]     in_normal_y,
  input  logic signed [pbsc_pkg::NORM_W-1:0]     in_normal_z,
  input  logic signed [pbsc_pkg::COORD_W-1:0]    in_point_x,
  input  logic signed [pbsc_pkg::COORD_W-1:0]    in_point_y,
  input  logic signed [pbsc_pkg::COORD_W-1:0]    in_point_z,
  input  logic                                   cfg_we,
  input  logic [pbsc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pbsc_pkg::SIZE_W-1:0]            cfg_wdata,
  output logic                                   out_valid,
  output logic signed [pbsc_pkg::COORD_W-1:0]    out_centroid_x,
  output logic signed [pbsc_pkg::COORD_W-1:0]    out_centroid_y,
  output logic signed [pbsc_pkg::COORD_W-1:0]    out_centroid_z,
  output logic [pbsc_pkg::CNT_W-1:0]             out_point_count,
  output logic                                   out_used_fallback
);

  localparam int NW  = pbsc_pkg::NORM_W;
  localparam int CW  = pbsc_pkg::COORD_W;
  localparam int SW  = pbsc_pkg::SIZE_W;
  localparam int UW  = pbsc_pkg::NUM_W;
  localparam int NE  = pbsc_pkg::NUM_EDGES;
  localparam int SMW = pbsc_pkg::SUM_W;
  localparam int MMW = pbsc_pkg::MMAG_W;
  localparam int MRW = pbsc_pkg::MREM_W;
  localparam int CNW = pbsc_pkg::CNT_W;
  localparam int MST = pbsc_pkg::MDIV_STAGES;
  localparam int LAT = 3 + pbsc_pkg::EDIV_LAT + 4 + MST + 1;

  logic [SW-1:0] size_r [3];
  logic [LAT-1:0] vld_r;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= pbsc_pkg::SIZE_RESET;
      size_r[1] <= pbsc_pkg::SIZE_RESET;
      size_r[2] <= pbsc_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (pbsc_pkg::cfg_reg_t'(cfg_index))
        pbsc_pkg::REG_BOX_X: size_r[0] <= cfg_wdata;
        pbsc_pkg::REG_BOX_Y: size_r[1] <= cfg_wdata;
        pbsc_pkg::REG_BOX_Z: size_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // stage 1: input registers
  logic signed [NW-1:0] n_r [3];
  logic signed [CW-1:0] p_r [3];
  logic signed [CW-1:0] pline_r [LAT-2];

  // stage 2: products
  logic signed [UW-1:0] prod0_r [3];
  logic signed [UW-1:0] prod1_r [3];
  logic signed [NW-1:0] den_r   [3];
  logic signed [CW:0]   diff_nxt [3];

  // stage 3: numerators
  logic signed [UW-1:0] num_r  [NE];
  logic signed [UW-1:0] num_nxt [NE];
  logic signed [NW-1:0] den3_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = {p_r[k][CW-1], p_r[k]} - {{(CW+1-SW){1'b0}}, size_r[k]};
    end
    for (int a = 0; a < 3; a++) begin
      for (int ee = 0; ee < 4; ee++) begin
        num_nxt[a*4+ee] = prod0_r[a]
          + (((ee % 2) == 1) ? prod1_r[(a+1)%3] : prod0_r[(a+1)%3])
          + ((ee >= 2) ? prod1_r[(a+2)%3] : prod0_r[(a+2)%3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r[0] <= in_normal_x;
    n_r[1] <= in_normal_y;
    n_r[2] <= in_normal_z;
    p_r[0] <= in_point_x;
    p_r[1] <= in_point_y;
    p_r[2] <= in_point_z;
    for (int k = 0; k < 3; k++) begin
      prod0_r[k] <= UW'(n_r[k]) * UW'(p_r[k]);
      prod1_r[k] <= UW'(n_r[k]) * UW'(diff_nxt[k]);
      den_r[k]   <= (n_r[k] == '0) ? NW'(1) : n_r[k];
      den3_r[k]  <= den_r[k];
    end
    for (int e = 0; e < NE; e++) begin
      num_r[e] <= num_nxt[e];
    end
  end

  // point line for the fallback, one entry per stage
  always_ff @(posedge clk) begin
    pline_r[0] <= p_r[0];
    for (int j = 1; j < LAT-2; j++) begin
      pline_r[j] <= pline_r[j-1];
    end
  end
  logic signed [CW-1:0] ply_r [LAT-2];
  logic signed [CW-1:0] plz_r [LAT-2];
  always_ff @(posedge clk) begin
    ply_r[0] <= p_r[1];
    plz_r[0] <= p_r[2];
    for (int j = 1; j < LAT-2; j++) begin
      ply_r[j] <= ply_r[j-1];
      plz_r[j] <= plz_r[j-1];
    end
  end

  // edge dividers
  logic signed [CW-1:0] q_w [NE];
  for (genvar e = 0; e < NE; e++) begin : g_edge
    localparam int AX = e / 4;
    pbsc_edge_div u_div (
      .clk   (clk),
      .num_i (num_r[e]),
      .den_i (den3_r[AX]),
      .q_o   (q_w[e])
    );
  end

  // box test and point coordinates
  logic signed [CW-1:0] crd_r   [NE][3];
  logic                 kept_r  [NE];
  logic signed [CW-1:0] crd_nxt [NE][3];
  logic                 kept_nxt [NE];

  always_comb begin
    logic signed [CW+1:0] qe;
    logic signed [CW+1:0] hi;
    int a;
    int ee;
    for (int e = 0; e < NE; e++) begin
      a  = e / 4;
      ee = e % 4;
      qe = (CW+2)'(q_w[e]);
      hi = $signed({3'b000, size_r[a]}) + (CW+2)'(1);
      kept_nxt[e] = (qe >= -(CW+2)'(1)) && (qe <= hi);
      crd_nxt[e][a] = kept_nxt[e] ? q_w[e] : '0;
      crd_nxt[e][(a+1)%3] = (kept_nxt[e] && (ee % 2) == 1) ?
                            $signed({1'b0, size_r[(a+1)%3]}) : '0;
      crd_nxt[e][(a+2)%3] = (kept_nxt[e] && ee >= 2) ?
                            $signed({1'b0, size_r[(a+2)%3]}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      kept_r[e] <= kept_nxt[e];
      for (int k = 0; k < 3; k++) begin
        crd_r[e][k] <= crd_nxt[e][k];
      end
    end
  end

  // adder tree: three groups of four, then the total
  logic signed [SMW-1:0] suma_r [3][3];
  logic [2:0]            cnta_r [3];
  logic signed [SMW-1:0] sum_r  [3];
  logic [CNW-1:0]        cnt_r;

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < 3; k++) begin
        suma_r[g][k] <= SMW'(crd_r[4*g][k]) + SMW'(crd_r[4*g+1][k])
                      + SMW'(crd_r[4*g+2][k]) + SMW'(crd_r[4*g+3][k]);
      end
      cnta_r[g] <= 3'(kept_r[4*g]) + 3'(kept_r[4*g+1])
                 + 3'(kept_r[4*g+2]) + 3'(kept_r[4*g+3]);
    end
    for (int k = 0; k < 3; k++) begin
      sum_r[k] <= suma_r[0][k] + suma_r[1][k] + suma_r[2][k];
    end
    cnt_r <= CNW'(cnta_r[0]) + CNW'(cnta_r[1]) + CNW'(cnta_r[2]);
  end

  // mean divider
  logic [MRW-1:0] mrem_r [MST+1][3];
  logic [MMW-1:0] mx_r   [MST+1][3];
  logic           mneg_r [MST+1][3];
  logic [CNW-1:0] mcnt_r [MST+1];
  logic [MRW-1:0] mrem_nxt [MST+1][3];
  logic [MMW-1:0] mx_nxt   [MST+1][3];

  always_comb begin
    logic [MRW:0] cand;
    logic         ge;
    cand = '0;
    ge   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      mrem_nxt[0][k] = '0;
      mx_nxt[0][k]   = sum_r[k][SMW-1] ? MMW'(-sum_r[k]) : MMW'(sum_r[k]);
    end
    for (int j = 0; j < MST; j++) begin
      for (int k = 0; k < 3; k++) begin
        mrem_nxt[j+1][k] = mrem_r[j][k];
        mx_nxt[j+1][k]   = mx_r[j][k];
        for (int s = 0; s < pbsc_pkg::MDIV_STEPS; s++) begin
          if (j * pbsc_pkg::MDIV_STEPS + s < MMW) begin
            cand = {mrem_nxt[j+1][k], mx_nxt[j+1][k][MMW-1]};
            ge   = cand >= {1'b0, mcnt_r[j]};
            if (ge) begin
              cand = cand - {1'b0, mcnt_r[j]};
            end
            mrem_nxt[j+1][k] = cand[MRW-1:0];
            mx_nxt[j+1][k]   = {mx_nxt[j+1][k][MMW-2:0], ge};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mcnt_r[0] <= cnt_r;
    for (int k = 0; k < 3; k++) begin
      mrem_r[0][k] <= mrem_nxt[0][k];
      mx_r[0][k]   <= mx_nxt[0][k];
      mneg_r[0][k] <= sum_r[k][SMW-1];
    end
    for (int j = 0; j < MST; j++) begin
      mcnt_r[j+1] <= mcnt_r[j];
      for (int k = 0; k < 3; k++) begin
        mrem_r[j+1][k] <= mrem_nxt[j+1][k];
        mx_r[j+1][k]   <= mx_nxt[j+1][k];
        mneg_r[j+1][k] <= mneg_r[j][k];
      end
    end
  end

  // output registers
  logic signed [CW-1:0] mean_nxt [3];
  logic                 fb_nxt;

  always_comb begin
    fb_nxt = (mcnt_r[MST] == '0);
    for (int k = 0; k < 3; k++) begin
      mean_nxt[k] = mneg_r[MST][k] ? CW'(-mx_r[MST][k]) : CW'(mx_r[MST][k]);
    end
  end

  always_ff @(posedge clk) begin
    out_centroid_x    <= fb_nxt ? pline_r[LAT-3] : mean_nxt[0];
    out_centroid_y    <= fb_nxt ? ply_r[LAT-3]   : mean_nxt[1];
    out_centroid_z    <= fb_nxt ? plz_r[LAT-3]   : mean_nxt[2];
    out_point_count   <= mcnt_r[MST];
    out_used_fallback <= fb_nxt;
  end

  assign out_valid = vld_r[LAT-1];

  `ASSERT_CLK(a_out_follows_in, out_valid |-> $past(accept, LAT),
              "result without a matching input transfer")
  `ASSERT_CLK(a_fallback_point, out_valid && out_used_fallback |->
              out_centroid_x == $past(in_point_x, LAT), "fallback point mismatch")
  `ASSERT_NEVER(a_count_range, out_valid && (out_point_count > CNW'(12)),
                "point count above twelve")
  `ASSERT_NEVER(a_fallback_count, out_valid && (out_used_fallback != (out_point_count == '0)),
                "fallback flag and count disagree")

endmodule

### src/pbsc_edge_div.sv
// ----------------------------------------------------------------------------
// pbsc_edge_div
// pipelined signed division of one edge numerator by a normal component,
// truncating toward zero and saturating to the 32 bit range
// ----------------------------------------------------------------------------
module pbsc_edge_div (
  input  logic                                 clk,
  input  logic signed [pbsc_pkg::NUM_W-1:0]    num_i,
  input  logic signed [pbsc_pkg::NORM_W-1:0]   den_i,
  output logic signed [pbsc_pkg::COORD_W-1:0]  q_o
);

  localparam int ST = pbsc_pkg::EDIV_STAGES;
  localparam int QB = pbsc_pkg::QB;
  localparam int RW = pbsc_pkg::REM_W;
  localparam int NW = pbsc_pkg::NORM_W;
  localparam int MW = pbsc_pkg::MAG_W;
  localparam int CW = pbsc_pkg::COORD_W;

  logic [RW-1:0] rem_r  [ST+1];
  logic [QB-1:0] x_r    [ST+1];
  logic [NW-1:0] aden_r [ST+1];
  logic          neg_r  [ST+1];
  logic          ovf_r  [ST+1];

  logic [RW-1:0] rem_nxt [ST+1];
  logic [QB-1:0] x_nxt   [ST+1];
  logic [NW-1:0] aden_nxt;
  logic [MW-1:0] anum_nxt;
  logic signed [CW-1:0] q_nxt;
  logic signed [CW-1:0] q_r;

  always_comb begin
    logic [NW:0]   denw;
    logic [RW:0]   cand;
    logic          ge;
    logic [QB-1:0] qv;
    denw     = den_i[NW-1] ? (NW+1)'(-den_i) : {1'b0, den_i};
    aden_nxt = denw[NW-1:0];
    anum_nxt = num_i[pbsc_pkg::NUM_W-1] ? MW'(-num_i) : MW'(num_i);
    rem_nxt[0] = anum_nxt[MW-1:QB];
    x_nxt[0]   = anum_nxt[QB-1:0];
    cand = '0;
    ge   = 1'b0;
    // each stage runs a few restoring steps
    for (int j = 0; j < ST; j++) begin
      rem_nxt[j+1] = rem_r[j];
      x_nxt[j+1]   = x_r[j];
      for (int s = 0; s < pbsc_pkg::EDIV_STEPS; s++) begin
        if (j * pbsc_pkg::EDIV_STEPS + s < QB) begin
          cand = {rem_nxt[j+1], x_nxt[j+1][QB-1]};
          ge   = cand >= {1'b0, aden_r[j]};
          if (ge) begin
            cand = cand - {1'b0, aden_r[j]};
          end
          rem_nxt[j+1] = cand[RW-1:0];
          x_nxt[j+1]   = {x_nxt[j+1][QB-2:0], ge};
        end
      end
    end
    // sign and saturation
    qv = x_r[ST];
    if (neg_r[ST]) begin
      if (ovf_r[ST] || qv > {{(QB-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}}) begin
        q_nxt = {1'b1, {(CW-1){1'b0}}};
      end else begin
        q_nxt = CW'(-qv);
      end
    end else begin
      if (ovf_r[ST] || qv > {{(QB-CW+1){1'b0}}, {(CW-1){1'b1}}}) begin
        q_nxt = {1'b0, {(CW-1){1'b1}}};
      end else begin
        q_nxt = CW'(qv);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem_nxt[0];
    x_r[0]    <= x_nxt[0];
    aden_r[0] <= aden_nxt;
    neg_r[0]  <= num_i[pbsc_pkg::NUM_W-1] ^ den_i[NW-1];
    ovf_r[0]  <= anum_nxt[MW-1:QB] >= aden_nxt;
    for (int j = 0; j < ST; j++) begin
      rem_r[j+1]  <= rem_nxt[j+1];
      x_r[j+1]    <= x_nxt[j+1];
      aden_r[j+1] <= aden_r[j];
      neg_r[j+1]  <= neg_r[j];
      ovf_r[j+1]  <= ovf_r[j];
    end
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// plane queries into plane_box_section_centroid, each result checked against
// a behavioral prediction over several box sizes, with random sender gaps in most phases
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pbsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint SIZE_MAX = 64'h7FFF_FFFF;
  localparam longint ONE = 65536;

  typedef struct {
    logic signed [pbsc_pkg::COORD_W-1:0] cx, cy, cz;
    logic [pbsc_pkg::CNT_W-1:0]          cnt;
    logic                                fb;
  } section_t;

  class section_scoreboard;
    longint box[3];
    section_t expected_q[$];
    int errors;

    function void reset_sizes();
      box[0] = longint'(pbsc_pkg::SIZE_RESET);
      box[1] = longint'(pbsc_pkg::SIZE_RESET);
      box[2] = longint'(pbsc_pkg::SIZE_RESET);
    endfunction

    function void set_size(logic [pbsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pbsc_pkg::SIZE_W-1:0] val);
      if (idx != REG_UNUSED) box[idx] = longint'(val);
    endfunction

    function section_t plane_section(longint n[3], longint p[3]);
      section_t r;
      longint sum[3], q[3], avg[3];
      longint num, den, t, u, v;
      int cnt, b, c;
      bit ok;
      sum = '{0, 0, 0};
      cnt = 0;
      for (int a = 0; a < 3; a++) begin
        b = (a + 1) % 3;
        c = (a + 2) % 3;
        for (int e = 0; e < 4; e++) begin
          u = e[0] ? box[b] : 0;
          v = e[1] ? box[c] : 0;
          num = n[a] * p[a] + n[b] * (p[b] - u) + n[c] * (p[c] - v);
          den = (n[a] == 0) ? 1 : n[a];
          t = num / den;
          if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
          if (t < -64'sh8000_0000) t = -64'sh8000_0000;
          q[a] = t; q[b] = u; q[c] = v;
          ok = 1;
          for (int k = 0; k < 3; k++)
            if (q[k] < -1 || q[k] > box[k] + 1) ok = 0;
          if (ok) begin
            for (int k = 0; k < 3; k++) sum[k] += q[k];
            cnt++;
          end
        end
      end
      for (int k = 0; k < 3; k++) avg[k] = (cnt == 0) ? p[k] : sum[k] / cnt;
      r.cx = avg[0][pbsc_pkg::COORD_W-1:0];
      r.cy = avg[1][pbsc_pkg::COORD_W-1:0];
      r.cz = avg[2][pbsc_pkg::COORD_W-1:0];
      r.cnt = cnt[pbsc_pkg::CNT_W-1:0];
      r.fb = (cnt == 0);
      return r;
    endfunction

    function void note_query(longint n[3], longint p[3]);
      expected_q.push_back(plane_section(n, p));
    endfunction

    function void check_result(section_t got);
      section_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: cnt %0d", $realtime, got.cnt);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.cx !== exp_r.cx) begin
        $display("%0t: centroid_x exp %0d got %0d", $realtime, exp_r.cx, got.cx);
        errors++;
      end
      if (got.cy !== exp_r.cy) begin
        $display("%0t: centroid_y exp %0d got %0d", $realtime, exp_r.cy, got.cy);
        errors++;
      end
      if (got.cz !== exp_r.cz) begin
        $display("%0t: centroid_z exp %0d got %0d", $realtime, exp_r.cz, got.cz);
        errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $display("%0t: point_count exp %0d got %0d", $realtime, exp_r.cnt, got.cnt);
        errors++;
      end
      if (got.fb !== exp_r.fb) begin
        $display("%0t: used_fallback exp %0d got %0d", $realtime, exp_r.fb, got.fb);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [pbsc_pkg::NORM_W-1:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic signed [pbsc_pkg::COORD_W-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic cfg_we = 1'b0;
  logic [pbsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pbsc_pkg::SIZE_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [pbsc_pkg::COORD_W-1:0] out_centroid_x, out_centroid_y, out_centroid_z;
  logic [pbsc_pkg::CNT_W-1:0] out_point_count;
  logic out_used_fallback;

  section_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  plane_box_section_centroid u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // transfer monitors
  always @(posedge clk) begin
    longint n[3], p[3];
    section_t got;
    if (rst_n && start && !busy) begin
      n = '{longint'(in_normal_x), longint'(in_normal_y), longint'(in_normal_z)};
      p = '{longint'(in_point_x), longint'(in_point_y), longint'(in_point_z)};
      sb.note_query(n, p);
    end
    if (rst_n && out_valid) begin
      got.cx = out_centroid_x; got.cy = out_centroid_y; got.cz = out_centroid_z;
      got.cnt = out_point_count; got.fb = out_used_fallback;
      sb.check_result(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("timeout at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_query(input longint nx, ny, nz, px, py, pz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_normal_x <= nx[pbsc_pkg::NORM_W-1:0];
    in_normal_y <= ny[pbsc_pkg::NORM_W-1:0];
    in_normal_z <= nz[pbsc_pkg::NORM_W-1:0];
    in_point_x <= px[pbsc_pkg::COORD_W-1:0];
    in_point_y <= py[pbsc_pkg::COORD_W-1:0];
    in_point_z <= pz[pbsc_pkg::COORD_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_size(input logic [pbsc_pkg::CFG_IDX_W-1:0] idx, input longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[pbsc_pkg::SIZE_W-1:0];
    @(posedge clk);
    sb.set_size(idx, val[pbsc_pkg::SIZE_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_norm();
    return longint'($signed(18'($urandom)));
  endfunction

  function automatic longint rand_in_box(int k);
    longint s;
    s = sb.box[k];
    if ($urandom_range(9) == 0) return longint'($signed(32'($urandom)));
    if (s == 0) return 0;
    return longint'($urandom_range(0, 32'(s)));
  endfunction

  task automatic random_queries(input int count);
    longint nx, ny, nz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        // well formed plane through a point near the box
        nx = longint'($urandom_range(0, 32'(2 * ONE))) - ONE;
        ny = longint'($urandom_range(0, 32'(2 * ONE))) - ONE;
        nz = longint'($urandom_range(0, 32'(2 * ONE))) - ONE;
        case ($urandom_range(5))
          0: nx = 0;
          1: ny = 0;
          2: nz = 0;
          default: ;
        endcase
        send_query(nx, ny, nz, rand_in_box(0), rand_in_box(1), rand_in_box(2));
      end else begin
        send_query(rand_norm(), rand_norm(), rand_norm(),
                   longint'($signed(32'($urandom))), longint'($signed(32'($urandom))),
                   longint'($signed(32'($urandom))));
      end
    end
  endtask

  initial begin
    sb.reset_sizes();
    idle_pct = 15;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_query(0, 0, 0, 0, 0, 0);
    send_query(ONE, 0, 0, 128 * ONE, 5, 7);
    send_query(0, ONE, 0, 3, 128 * ONE, 9);
    send_query(0, 0, ONE, 1, 2, 128 * ONE);
    send_query(-ONE, 0, 0, 256 * ONE, 0, 0);
    send_query(37837, 37837, 37837, 128 * ONE, 128 * ONE, 128 * ONE);
    send_query(131071, -131072, 1, 0, 0, 0);
    send_query(-131072, 131071, -1, 32'h7FFF_FFFF, -32'sh8000_0000, 0);
    send_query(1, 1, 1, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    send_query(0, 0, 1, 0, 0, 32'h7FFF_FFFF);
    send_query(ONE, 0, 0, -1, 0, 0);
    send_query(ONE, 0, 0, -2, 0, 0);
    send_query(ONE, 0, 0, 256 * ONE + 1, 0, 0);
    send_query(ONE, 0, 0, 256 * ONE + 2, 0, 0);
    send_query(46341, 46341, 0, 256 * ONE, 0, 0);
    send_query(3, -7, 11, 1000, -1000, 333);
    send_query(-131072, -131072, -131072, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(ONE, ONE, 0, 200 * ONE, 100 * ONE, 50 * ONE);
    random_queries(500);
    drain();

    // extremes of the box
    write_size(pbsc_pkg::REG_BOX_X, SIZE_MAX);
    write_size(pbsc_pkg::REG_BOX_Y, 1);
    write_size(pbsc_pkg::REG_BOX_Z, SIZE_MAX);
    write_size(REG_UNUSED, 0);
    random_queries(350);
    drain();

    idle_pct = 79;
    write_size(pbsc_pkg::REG_BOX_X, 0);
    write_size(pbsc_pkg::REG_BOX_Y, SIZE_MAX);
    write_size(pbsc_pkg::REG_BOX_Z, 1);
    send_query(ONE, ONE, ONE, 0, 0, 0);
    send_query(0, ONE, 0, 0, 0, 0);
    random_queries(350);
    drain();

    idle_pct = 0;
    write_size(pbsc_pkg::REG_BOX_X, 4 * ONE);
    write_size(pbsc_pkg::REG_BOX_Y, 3 * ONE);
    write_size(pbsc_pkg::REG_BOX_Z, 5 * ONE);
    random_queries(350);
    drain();

    write_size(pbsc_pkg::REG_BOX_X, $urandom_range(1, 32'h7FFF_FFFF));
    write_size(pbsc_pkg::REG_BOX_Y, $urandom_range(1, 32'h00FF_FFFF));
    write_size(pbsc_pkg::REG_BOX_Z, $urandom_range(1, 32'h0FFF_FFFF));
    random_queries(380);
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
